@@ src/locd_pkg.sv @@
// Package for the lock order cycle detector: sizes, types and the walk state encoding.
// Used by every module in src; depends on nothing.
package locd_pkg;
  localparam int NUM_LOCKS   = 32;
  localparam int NUM_THREADS = 8;
  localparam int STACK_DEPTH = 16;
  localparam int LW = $clog2(NUM_LOCKS);
  localparam int TW = $clog2(NUM_THREADS);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int RW = $clog2(NUM_LOCKS + 1);

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Command from the front end to the graph engine.
  typedef struct packed {
    logic          edge_new;
    logic [LW-1:0] from;
    logic [LW-1:0] to;
    logic          fault;
  } cmd_t;

  typedef struct packed {
    logic          edge_added;
    logic          deadlock;
    logic [LW-1:0] back_from;
    logic [LW-1:0] back_to;
    logic          stack_fault;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROOT, ST_SCAN, ST_DONE
  } walk_state_t;
endpackage

@@ src/locd_front.sv @@
// Front end: per-thread lock stacks, classifies each item into a graph command.
// Depends on locd_pkg; queries the edge bitmap held by locd_engine.
module locd_front
  import locd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [TW-1:0]       thread_id,
  input  logic [LW-1:0]       lock_id,
  output logic [LW-1:0]       probe_from,
  input  logic [NUM_LOCKS-1:0] probe_row,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output cmd_t                cmd
);
  logic [LW-1:0] held_mem [NUM_THREADS*STACK_DEPTH];
  logic [CW-1:0] held_count_r [NUM_THREADS];
  logic [LW-1:0] top_r;
  logic          top_ok_r;
  logic          ph_r;          // 0: read top, 1: decide
  logic          op_r;
  logic [TW-1:0] tid_r;
  logic [LW-1:0] lock_r;
  logic [CW-1:0] cnt;
  logic          acc;
  cmd_t          cmd_nxt;
  logic          push;

  assign in_ready = !ph_r;
  assign acc = in_valid && in_ready;
  assign cnt = held_count_r[tid_r];
  assign probe_from = top_r;
  assign cmd_valid = ph_r;

  always_comb begin
    cmd_nxt = '0;
    push = 1'b0;
    if (op_r == OP_RELEASE) begin
      cmd_nxt.fault = (cnt == '0);
    end else if (cnt >= CW'(STACK_DEPTH)) begin
      cmd_nxt.fault = 1'b1;
    end else begin
      push = 1'b1;
      if (top_ok_r && top_r != lock_r && !probe_row[lock_r]) begin
        cmd_nxt.edge_new = 1'b1;
      end
    end
    cmd_nxt.from = top_r;
    cmd_nxt.to = lock_r;
  end
  assign cmd = cmd_nxt;

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r <= op;
      tid_r <= thread_id;
      lock_r <= lock_id;
    end
    if (ph_r && !acc) begin
      // nothing
    end
    if (ph_r && cmd_ready && push) begin
      held_mem[{tid_r, cnt[SW-1:0]}] <= lock_r;
    end
  end

  // Top of stack is registered when the item is accepted.
  logic [CW-1:0] acnt;
  logic [SW-1:0] tidx;
  assign acnt = held_count_r[thread_id];
  assign tidx = SW'(acnt - CW'(1));
  always_ff @(posedge clk) begin
    if (acc) begin
      top_r <= held_mem[{thread_id, tidx}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 1'b0;
      top_ok_r <= 1'b0;
      for (int i = 0; i < NUM_THREADS; i++) held_count_r[i] <= '0;
    end else begin
      if (acc) begin
        ph_r <= 1'b1;
        top_ok_r <= (acnt != '0);
      end else if (ph_r && cmd_ready) begin
        ph_r <= 1'b0;
        if (push) held_count_r[tid_r] <= cnt + CW'(1);
        else if (op_r == OP_RELEASE && cnt != '0) held_count_r[tid_r] <= cnt - CW'(1);
      end
    end
  end
endmodule

@@ src/locd_queue.sv @@
// Two-entry command queue between front end and graph engine.
// Depends on locd_pkg.
module locd_queue
  import locd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

@@ src/locd_engine.sv @@
// Graph engine: edge bitmaps, iterative depth-first walk and result register.
// Depends on locd_pkg.
module locd_engine
  import locd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LW-1:0]        probe_from,
  output logic [NUM_LOCKS-1:0] probe_row,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res
);
  logic [NUM_LOCKS-1:0] edges_r [NUM_LOCKS];
  logic [LW-1:0] wnode_r [NUM_LOCKS];
  logic [RW-1:0] wnext_r [NUM_LOCKS];
  logic [LW:0]   rank_r [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] vis_r, fin_r;
  logic [RW-1:0] sp_r, rank_cnt_r, root_r;
  walk_state_t st_r, st_nxt;
  res_t res_r;
  logic res_v_r;

  logic [LW-1:0] u;
  logic [RW-1:0] v;
  logic [LW-1:0] vl;
  logic          hit;
  logic          new_edge;

  assign probe_row = edges_r[probe_from];
  assign res_valid = res_v_r;
  assign res = res_r;
  assign cmd_ready = (st_r == ST_IDLE) && !res_v_r;
  assign u = wnode_r[sp_r[LW-1:0] - LW'(1)];
  assign v = wnext_r[sp_r[LW-1:0] - LW'(1)];
  assign vl = v[LW-1:0];
  assign hit = (v < RW'(NUM_LOCKS)) && edges_r[u][vl];
  // The front end probes before earlier queued commands are applied, so the
  // edge is checked again here, where commands are applied in order.
  assign new_edge = cmd.edge_new && !edges_r[cmd.from][cmd.to];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (cmd_valid && cmd_ready && new_edge) st_nxt = ST_ROOT;
      ST_ROOT: if (root_r == RW'(NUM_LOCKS)) st_nxt = ST_DONE;
               else if (!vis_r[root_r[LW-1:0]]) st_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sp_r == '0) st_nxt = ST_ROOT;
        else if (hit && vis_r[vl] && rank_r[u] >= rank_r[vl] && !fin_r[vl]) st_nxt = ST_DONE;
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        vis_r <= '0;
        fin_r <= '0;
        root_r <= '0;
        rank_cnt_r <= '0;
        sp_r <= '0;
        if (cmd_valid && cmd_ready) begin
          res_r.back_from <= '0;
          res_r.back_to <= '0;
          res_r.deadlock <= 1'b0;
          res_r.edge_added <= new_edge;
          res_r.stack_fault <= cmd.fault;
        end
      end
      ST_ROOT: begin
        if (root_r != RW'(NUM_LOCKS)) begin
          if (!vis_r[root_r[LW-1:0]]) begin
            vis_r[root_r[LW-1:0]] <= 1'b1;
            rank_r[root_r[LW-1:0]] <= rank_cnt_r[LW:0];
            rank_cnt_r <= rank_cnt_r + RW'(1);
            wnode_r[0] <= root_r[LW-1:0];
            wnext_r[0] <= '0;
            sp_r <= RW'(1);
          end
          root_r <= root_r + RW'(1);
        end
      end
      ST_SCAN: begin
        if (sp_r != '0) begin
          if (v >= RW'(NUM_LOCKS)) begin
            fin_r[u] <= 1'b1;
            sp_r <= sp_r - RW'(1);
          end else if (!hit) begin
            wnext_r[sp_r[LW-1:0] - LW'(1)] <= v + RW'(1);
          end else begin
            wnext_r[sp_r[LW-1:0] - LW'(1)] <= v + RW'(1);
            if (!vis_r[vl]) begin
              vis_r[vl] <= 1'b1;
              rank_r[vl] <= rank_cnt_r[LW:0];
              rank_cnt_r <= rank_cnt_r + RW'(1);
              if (sp_r < RW'(NUM_LOCKS)) begin
                wnode_r[sp_r[LW-1:0]] <= vl;
                wnext_r[sp_r[LW-1:0]] <= '0;
                sp_r <= sp_r + RW'(1);
              end
            end else if (rank_r[u] >= rank_r[vl] && !fin_r[vl]) begin
              res_r.deadlock <= 1'b1;
              res_r.back_from <= u;
              res_r.back_to <= vl;
            end
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      res_v_r <= 1'b0;
      for (int i = 0; i < NUM_LOCKS; i++) edges_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && cmd_valid && cmd_ready) begin
        if (new_edge) edges_r[cmd.from][cmd.to] <= 1'b1;
        else res_v_r <= 1'b1;
      end else if (st_r == ST_DONE) begin
        res_v_r <= 1'b1;
      end else if (res_v_r && res_ready) begin
        res_v_r <= 1'b0;
      end
    end
  end
endmodule

@@ src/lock_order_cycle_detector_top.sv @@
// Lock order cycle detector: the front end takes a new item only once it has handed the
// command of the last one to the queue. An item that adds a new edge runs a depth-first walk
// that scans one successor per cycle, node by node and root by root; a deadlock ends the walk
// early. The front end takes the next item while the engine walks, as long as the queue has
// room; the two-entry queue decouples them.
// Synchronous active-low reset clears thread stack depths, the edge bitmaps and all control.
module lock_order_cycle_detector_top
  import locd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // op
  input  logic [7:0]  in_tdata,   // thread_id[2:0], lock_id[7:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // edge_added, deadlock, back_from, back_to, stack_fault
);
  logic [LW-1:0] probe_from;
  logic [NUM_LOCKS-1:0] probe_row;
  logic fq_v, fq_r, qe_v, qe_r;
  cmd_t fq_d, qe_d;
  res_t res;

  locd_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .op(in_tuser[0]),
    .thread_id(in_tdata[2:0]), .lock_id(in_tdata[7:3]), .probe_from, .probe_row,
    .cmd_valid(fq_v), .cmd_ready(fq_r), .cmd(fq_d)
  );
  locd_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_v), .wr_ready(fq_r), .wr_data(fq_d),
    .rd_valid(qe_v), .rd_ready(qe_r), .rd_data(qe_d)
  );
  locd_engine u_engine (
    .clk, .rst_n, .probe_from, .probe_row, .cmd_valid(qe_v), .cmd_ready(qe_r), .cmd(qe_d),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );
  assign out_tdata = {3'b000, res.stack_fault, res.back_to, res.back_from,
                      res.deadlock, res.edge_added};
endmodule

@@ tb/sv/lock_order_cycle_detector_checker.sv @@
// Checker for the lock order cycle detector: watches both stream channels, predicts each
// result from the accepted items and compares it field by field. Depends on locd_pkg.
module lock_order_cycle_detector_checker
  import locd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [0:0]  in_tuser,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          err_count,
  output int          pending,
  output int          n_edges,
  output int          n_deadlocks,
  output int          n_faults
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [NUM_LOCKS-1:0] graph [NUM_LOCKS];
  logic [LW-1:0]        held [NUM_THREADS][STACK_DEPTH];
  int                   depth [NUM_THREADS];
  res_t                 expected_q [$];

  // Depth-first walk from lock 0 upward; successors taken in ascending order.
  function automatic bit find_back_edge(output logic [LW-1:0] bf, output logic [LW-1:0] bt);
    int rank;
    int vrank [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] seen, done;
    int fnode [NUM_LOCKS];
    int fnext [NUM_LOCKS];
    int sp, u, v;
    rank = 0;
    seen = '0;
    done = '0;
    bf = '0;
    bt = '0;
    for (int root = 0; root < NUM_LOCKS; root++) begin
      if (seen[root]) continue;
      seen[root] = 1'b1;
      vrank[root] = rank++;
      fnode[0] = root;
      fnext[0] = 0;
      sp = 1;
      while (sp > 0) begin
        u = fnode[sp-1];
        v = fnext[sp-1];
        while (v < NUM_LOCKS && !graph[u][v]) v++;
        if (v >= NUM_LOCKS) begin
          done[u] = 1'b1;
          sp--;
          continue;
        end
        fnext[sp-1] = v + 1;
        if (!seen[v]) begin
          seen[v] = 1'b1;
          vrank[v] = rank++;
          if (sp < NUM_LOCKS) begin
            fnode[sp] = v;
            fnext[sp] = 0;
            sp++;
          end
          continue;
        end
        if (vrank[u] < vrank[v]) continue;
        if (!done[v]) begin
          bf = u[LW-1:0];
          bt = v[LW-1:0];
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t apply_item(logic op, logic [TW-1:0] tid, logic [LW-1:0] lk);
    res_t r;
    int cnt;
    logic [LW-1:0] top;
    r = '0;
    cnt = depth[tid];
    if (op == OP_RELEASE) begin
      if (cnt == 0) r.stack_fault = 1'b1;
      else depth[tid] = cnt - 1;
    end else if (cnt >= STACK_DEPTH) begin
      r.stack_fault = 1'b1;
    end else begin
      if (cnt > 0) begin
        top = held[tid][cnt-1];
        if (top != lk && !graph[top][lk]) begin
          graph[top][lk] = 1'b1;
          r.edge_added = 1'b1;
          r.deadlock = find_back_edge(r.back_from, r.back_to);
        end
      end
      held[tid][cnt] = lk;
      depth[tid] = cnt + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LOCKS; i++) graph[i] = '0;
      for (int i = 0; i < NUM_THREADS; i++) depth[i] = 0;
      expected_q.delete();
      err_count <= 0;
      n_edges <= 0;
      n_deadlocks <= 0;
      n_faults <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.edge_added = out_tdata[0];
        got.deadlock = out_tdata[1];
        got.back_from = out_tdata[6:2];
        got.back_to = out_tdata[11:7];
        got.stack_fault = out_tdata[12];
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          err_count <= err_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want || out_tdata[15:13] !== '0) begin
            $display("%0t: mismatch expected edge=%0b dead=%0b from=%0d to=%0d fault=%0b",
                     $time, want.edge_added, want.deadlock, want.back_from, want.back_to,
                     want.stack_fault);
            $display("%0t:          actual   edge=%0b dead=%0b from=%0d to=%0d fault=%0b",
                     $time, got.edge_added, got.deadlock, got.back_from, got.back_to,
                     got.stack_fault);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_item(in_tuser[0], in_tdata[TW-1:0], in_tdata[TW+LW-1:TW]);
        expected_q.push_back(want);
        n_edges <= n_edges + want.edge_added;
        n_deadlocks <= n_deadlocks + want.deadlock;
        n_faults <= n_faults + want.stack_fault;
      end
    end
    pending <= expected_q.size();
  end
endmodule

@@ tb/sv/lock_order_cycle_detector_top_tb.sv @@
// Testbench top for the lock order cycle detector: clock, reset, stimulus and verdict.
// Depends on locd_pkg, lock_order_cycle_detector_top and lock_order_cycle_detector_checker.
module lock_order_cycle_detector_top_tb;
  import locd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 10000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [0:0]  in_tuser = '0;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  int          err_count, pending, n_edges, n_deadlocks, n_faults;
  int          cycles = 0;
  int          n_sent = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          shadow_depth [NUM_THREADS];

  always #10 clk = ~clk;

  lock_order_cycle_detector_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  lock_order_cycle_detector_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .err_count(err_count), .pending(pending), .n_edges(n_edges),
    .n_deadlocks(n_deadlocks), .n_faults(n_faults)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none near the end.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic op, logic [TW-1:0] tid, logic [LW-1:0] lk);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {lk, tid};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    if (op == OP_RELEASE) begin
      if (shadow_depth[tid] > 0) shadow_depth[tid]--;
    end else if (shadow_depth[tid] < STACK_DEPTH) begin
      shadow_depth[tid]++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int tid, lk, r;
    for (int i = 0; i < NUM_THREADS; i++) shadow_depth[i] = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: release on an empty stack, re-acquire of the top lock, a two-lock cycle.
    send_item(OP_RELEASE, 0, 0);
    send_item(OP_ACQUIRE, 0, 0);
    send_item(OP_ACQUIRE, 0, 0);
    send_item(OP_ACQUIRE, 0, 31);
    send_item(OP_ACQUIRE, 0, 0);
    // An edge that is already present.
    send_item(OP_ACQUIRE, 1, 0);
    send_item(OP_ACQUIRE, 1, 31);
    // Fill one stack to the top, then one acquire too many.
    for (int i = 0; i <= STACK_DEPTH; i++) send_item(OP_ACQUIRE, 7, 31);
    wait_drained();

    // Random part: mostly balanced acquire and release traffic over a few locks.
    for (int i = 0; i < 1526; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == 700) wait_drained();
      if (i == 1350) calm = 1'b1;
      tid = $urandom_range(0, NUM_THREADS - 1);
      lk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_LOCKS - 1)
                                        : $urandom_range(0, 9);
      r = $urandom_range(0, 99);
      if (r < 5)
        send_item(1'($urandom_range(0, 1)), TW'(tid), LW'(lk));
      else if (shadow_depth[tid] == 0 || (shadow_depth[tid] < 6 && r < 60))
        send_item(OP_ACQUIRE, TW'(tid), LW'(lk));
      else
        send_item(OP_RELEASE, TW'(tid), LW'(lk));
    end
    wait_drained();
    repeat (1200) @(negedge clk);

    $display("sent %0d items: %0d new edges, %0d deadlocks, %0d stack faults", n_sent,
             n_edges, n_deadlocks, n_faults);
    if (err_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
